// ----- design/mss_pkg.sv -----
// shared types, constants and register codes for the masked signature scanner
// no dependencies
package mss_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int ADDR_BITS         = 32;
	localparam int SCAN_STRIDE       = 4;

	localparam int BYTE_W   = 8;
	localparam int REG_W    = 64;
	localparam int LEN_W    = 5;
	localparam int TGT_W    = 4;
	localparam int LIMIT_W  = 16;
	localparam int CNT_W    = 16;
	localparam int POS_W    = 32;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 3;

	localparam int RES_DEPTH   = 4;
	localparam int RES_PTR_W   = $clog2(RES_DEPTH);
	localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_MASK_LOW       = 3'd2,
		REG_MASK_HIGH      = 3'd3,
		REG_PATTERN_LENGTH = 3'd4,
		REG_TARGET_OFFSET  = 3'd5,
		REG_MATCH_LIMIT    = 3'd6
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_UNIQUE   = 3'd0,
		ST_NONE     = 3'd1,
		ST_MULTIPLE = 3'd2,
		ST_INVALID  = 3'd3,
		ST_NO_FIXED = 3'd4
	} status_t;

	typedef enum logic {
		KIND_MATCH   = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		logic [REG_W-1:0]   pattern_low;
		logic [REG_W-1:0]   pattern_high;
		logic [REG_W-1:0]   mask_low;
		logic [REG_W-1:0]   mask_high;
		logic [LEN_W-1:0]   pattern_length;
		logic [TGT_W-1:0]   target_offset;
		logic [LIMIT_W-1:0] match_limit;
	} cfg_t;

	typedef struct packed {
		kind_t         kind;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] match_count;
		status_t       status;
		logic          last_result;
	} res_t;

	// v1 is only set together with v0
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} res_push_t;

endpackage

// ----- design/mss_if.sv -----
// item channels of the masked signature scanner: input bytes and results
// depends on mss_pkg
interface mss_in_if;
	import mss_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface mss_out_if;
	import mss_pkg::*;

	logic                valid;
	logic                ready;
	logic                kind;
	logic [POS_W-1:0]    position;
	logic [CNT_W-1:0]    match_count;
	logic [STATUS_W-1:0] status;
	logic                last_result;

	modport source (output valid, kind, position, match_count, status, last_result,
		input ready);
	modport sink (input valid, kind, position, match_count, status, last_result,
		output ready);
endinterface

// ----- design/masked_signature_scanner.sv -----
// Masked signature scanner, top level: one byte item in, match and summary items out.
// Takes one byte per cycle while the result queue has room; an item is registered,
// compared against the 16-byte window from that register and its results land in
// a four-entry result queue. The result port gives one item per cycle while the sink
// is ready, so a buffer's last byte that also matches yields both a match and a
// summary item; input is held off only when that queue has fewer than two free entries.
// Depends on mss_pkg, mss_if, mss_cfg_regs, mss_scan and mss_res_fifo.
module masked_signature_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mss_pkg::REG_W-1:0]     cfg_wdata,
	mss_in_if.sink                        src,
	mss_out_if.source                     dst
);
	import mss_pkg::*;

	cfg_t      cfg;
	res_push_t push;
	res_t      out_res;
	logic      room;

	mss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mss_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (src.valid),
		.in_ready     (src.ready),
		.in_data_byte (src.data_byte),
		.in_last_byte (src.last_byte),
		.room         (room),
		.push         (push)
	);

	mss_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (dst.valid),
		.out_ready (dst.ready),
		.out_res   (out_res)
	);

	assign dst.kind        = out_res.kind;
	assign dst.position    = out_res.position;
	assign dst.match_count = out_res.match_count;
	assign dst.status      = out_res.status;
	assign dst.last_result = out_res.last_result;

endmodule

// ----- design/mss_cfg_regs.sv -----
// configuration register file of the masked signature scanner
// depends on mss_pkg
module mss_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mss_pkg::REG_W-1:0]     cfg_wdata,
	output mss_pkg::cfg_t                 cfg
);
	import mss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{match_limit: LIMIT_RESET, default: '0};
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:    cfg_q.pattern_low    <= cfg_wdata;
				REG_PATTERN_HIGH:   cfg_q.pattern_high   <= cfg_wdata;
				REG_MASK_LOW:       cfg_q.mask_low       <= cfg_wdata;
				REG_MASK_HIGH:      cfg_q.mask_high      <= cfg_wdata;
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_wdata[LEN_W-1:0];
				REG_TARGET_OFFSET:  cfg_q.target_offset  <= cfg_wdata[TGT_W-1:0];
				REG_MATCH_LIMIT:    cfg_q.match_limit    <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/mss_scan.sv -----
// input register, sliding window, masked compare and scan state
// depends on mss_pkg
module mss_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mss_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mss_pkg::BYTE_W-1:0] in_data_byte,
	input  logic                       in_last_byte,
	input  logic                       room,
	output mss_pkg::res_push_t         push
);
	import mss_pkg::*;

	localparam int WIN_W = MAX_PATTERN_BYTES * BYTE_W;

	logic                                   valid_s1;
	logic [BYTE_W-1:0]                      byte_s1;
	logic                                   last_s1;

	logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] win_q;
	logic [ADDR_BITS-1:0]                   pos_q;
	logic [CNT_W-1:0]                       found_q;
	logic                                   limit_q;

	logic                                   adv;
	logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] win_shift;
	logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] aligned;
	logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] pat;
	logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] msk;
	logic [MAX_PATTERN_BYTES-1:0]           used;
	logic [MAX_PATTERN_BYTES-1:0]           byte_ok;
	logic [LEN_W-1:0]                       len;
	logic [LEN_W-1:0]                       shamt;
	logic                                   invalid;
	logic                                   fixed;
	logic                                   any_mask;
	logic [ADDR_BITS-1:0]                   seen;
	logic [ADDR_BITS-1:0]                   start;
	logic                                   try_cmp;
	logic                                   hit;
	logic [CNT_W-1:0]                       found_next;
	logic                                   limit_next;
	status_t                                sum_status;
	res_t                                   match_res;
	res_t                                   sum_res;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_data_byte;
			last_s1 <= in_last_byte;
		end
	end

	// signature check, from configuration only
	always_comb begin
		len      = cfg.pattern_length;
		pat      = {cfg.pattern_high, cfg.pattern_low};
		msk      = {cfg.mask_high, cfg.mask_low};
		any_mask = 1'b0;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			used[i]  = LEN_W'(i) < len;
			any_mask = any_mask | (used[i] && (msk[i] != '0));
		end
		invalid = (len == '0) || (len > LEN_W'(MAX_PATTERN_BYTES)) ||
			(cfg.match_limit == '0) || ({1'b0, cfg.target_offset} >= len);
		fixed   = !invalid && any_mask;
	end

	// window compare, newest byte at the top
	always_comb begin
		win_shift = {byte_s1, win_q[MAX_PATTERN_BYTES-1:1]};
		shamt     = LEN_W'(MAX_PATTERN_BYTES) - len;
		aligned   = WIN_W'(win_shift >> {shamt, 3'b000});
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			byte_ok[i] = !used[i] || (((aligned[i] ^ pat[i]) & msk[i]) == '0);
		end
		seen    = pos_q + ADDR_BITS'(1);
		start   = seen - ADDR_BITS'(len);
		try_cmp = fixed && !limit_q && (seen >= ADDR_BITS'(len)) &&
			((start % SCAN_STRIDE) == '0);
		hit     = try_cmp && (&byte_ok);
	end

	always_comb begin
		found_next = hit ? found_q + CNT_W'(1) : found_q;
		limit_next = limit_q || (hit && (found_next == cfg.match_limit));

		if (invalid)
			sum_status = ST_INVALID;
		else if (!fixed)
			sum_status = ST_NO_FIXED;
		else if (found_next == '0)
			sum_status = ST_NONE;
		else if (found_next == CNT_W'(1))
			sum_status = ST_UNIQUE;
		else
			sum_status = ST_MULTIPLE;

		match_res.kind        = KIND_MATCH;
		match_res.position    = POS_W'(start + ADDR_BITS'(cfg.target_offset));
		match_res.match_count = found_next;
		match_res.status      = ST_UNIQUE;
		match_res.last_result = !last_s1;

		sum_res.kind          = KIND_SUMMARY;
		sum_res.position      = '0;
		sum_res.match_count   = found_next;
		sum_res.status        = sum_status;
		sum_res.last_result   = 1'b1;

		push.v0 = adv && (hit || last_s1);
		push.v1 = adv && hit && last_s1;
		push.r0 = hit ? match_res : sum_res;
		push.r1 = sum_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			pos_q   <= '0;
			found_q <= '0;
			limit_q <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				win_q   <= '0;
				pos_q   <= '0;
				found_q <= '0;
				limit_q <= 1'b0;
			end else begin
				win_q   <= win_shift;
				pos_q   <= seen;
				found_q <= found_next;
				limit_q <= limit_next;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> pos_q == '0 && found_q == '0 && !limit_q)
		else $error("scan state not cleared after last item");

	a_limit_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q |-> found_q != '0)
		else $error("limit flag set with zero count");

	a_no_hit_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q || !fixed |-> !hit)
		else $error("match reported past limit or without fixed bits");

	a_second_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && push.r0.kind == KIND_MATCH)
		else $error("second result without a preceding match");

endmodule

// ----- design/mss_res_fifo.sv -----
// four-entry result queue, takes up to two results per cycle, gives one
// depends on mss_pkg
module mss_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  mss_pkg::res_push_t push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output mss_pkg::res_t      out_res
);
	import mss_pkg::*;

	res_t [RES_DEPTH-1:0] mem_q;
	logic [RES_PTR_W-1:0] wr_q;
	logic [RES_PTR_W-1:0] rd_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;
	logic [RES_CNT_W-1:0] n_push;
	logic [RES_PTR_W-1:0] wr_next1;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rd_q];
	assign room      = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);
	assign n_push    = RES_CNT_W'(push.v0) + RES_CNT_W'(push.v1);
	assign wr_next1  = wr_q + RES_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wr_q] <= push.r0;
		if (push.v1)
			mem_q[wr_next1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RES_PTR_W'(n_push);
			rd_q  <= rd_q + RES_PTR_W'(pop);
			cnt_q <= cnt_q + n_push - RES_CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> room)
		else $error("result pushed without room");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> rd_q == wr_q)
		else $error("empty queue with pointers apart");

endmodule

// ----- verif/mss_scan_checker.sv -----
// checker for the masked signature scanner: tracks register writes, predicts the
// match and summary items of every accepted byte and compares them in order
// depends on mss_pkg and mss_if
module mss_scan_checker
	import mss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	mss_in_if                    in_mon,
	mss_out_if                   res_mon,
	output int                   fail_count,
	output int                   pending
);

	cfg_t             regs;
	logic [7:0]       window [MAX_PATTERN_BYTES];
	logic [POS_W-1:0] seen_bytes;
	logic [CNT_W-1:0] hit_count;
	logic             limit_hit;
	res_t             due_q[$];

	task automatic clear_scan();
		foreach (window[i]) window[i] = '0;
		seen_bytes = '0;
		hit_count  = '0;
		limit_hit  = 1'b0;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic last);
		logic [127:0]     pat;
		logic [127:0]     msk;
		logic             bad;
		logic             fixed;
		logic             equal;
		logic [POS_W-1:0] seen;
		logic [POS_W-1:0] start;
		logic [7:0]       m;
		int               base;
		res_t             r;
		pat = {regs.pattern_high, regs.pattern_low};
		msk = {regs.mask_high, regs.mask_low};
		bad = regs.pattern_length == 0 || regs.pattern_length > MAX_PATTERN_BYTES ||
			regs.match_limit == 0 || regs.target_offset >= regs.pattern_length;
		fixed = 1'b0;
		if (!bad) begin
			for (int i = 0; i < regs.pattern_length; i++) begin
				if (msk[i*8 +: 8] != 8'h00) begin
					fixed = 1'b1;
				end
			end
		end
		for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
			window[i] = window[i+1];
		end
		window[MAX_PATTERN_BYTES-1] = b;
		seen = seen_bytes + 1'b1;
		if (fixed && !limit_hit && seen >= regs.pattern_length) begin
			start = seen - regs.pattern_length;
			if (start % SCAN_STRIDE == 0) begin
				base  = MAX_PATTERN_BYTES - regs.pattern_length;
				equal = 1'b1;
				for (int i = 0; i < regs.pattern_length; i++) begin
					m = msk[i*8 +: 8];
					if ((window[base+i] & m) != (pat[i*8 +: 8] & m)) begin
						equal = 1'b0;
					end
				end
				if (equal) begin
					hit_count = hit_count + 1'b1;
					if (hit_count == regs.match_limit) begin
						limit_hit = 1'b1;
					end
					r.kind        = KIND_MATCH;
					r.position    = start + regs.target_offset;
					r.match_count = hit_count;
					r.status      = ST_UNIQUE;
					r.last_result = !last;
					due_q = {due_q, r};
				end
			end
		end
		seen_bytes = seen;
		if (last) begin
			r.kind        = KIND_SUMMARY;
			r.position    = '0;
			r.match_count = hit_count;
			r.last_result = 1'b1;
			if (bad) begin
				r.status = ST_INVALID;
			end else if (!fixed) begin
				r.status = ST_NO_FIXED;
			end else if (hit_count == 0) begin
				r.status = ST_NONE;
			end else if (hit_count == 1) begin
				r.status = ST_UNIQUE;
			end else begin
				r.status = ST_MULTIPLE;
			end
			due_q = {due_q, r};
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			regs             = '0;
			regs.match_limit = LIMIT_RESET;
			clear_scan();
			due_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PATTERN_LOW:    regs.pattern_low    = cfg_wdata;
					REG_PATTERN_HIGH:   regs.pattern_high   = cfg_wdata;
					REG_MASK_LOW:       regs.mask_low       = cfg_wdata;
					REG_MASK_HIGH:      regs.mask_high      = cfg_wdata;
					REG_PATTERN_LENGTH: regs.pattern_length = cfg_wdata[LEN_W-1:0];
					REG_TARGET_OFFSET:  regs.target_offset  = cfg_wdata[TGT_W-1:0];
					REG_MATCH_LIMIT:    regs.match_limit    = cfg_wdata[LIMIT_W-1:0];
					default: begin
					end
				endcase
			end
			// results leave before the new byte is scanned, so an early result
			// never pairs with a fresh expectation
			if (res_mon.valid && res_mon.ready) begin
				if (due_q.size() == 0) begin
					$display("%0t unexpected result item: kind %0d pos %0h count %0d status %0d last %0d",
						$time, res_mon.kind, res_mon.position, res_mon.match_count,
						res_mon.status, res_mon.last_result);
					fail_count++;
				end else begin
					exp_r = due_q.pop_front();
					if (res_mon.kind !== exp_r.kind || res_mon.position !== exp_r.position ||
						res_mon.match_count !== exp_r.match_count ||
						res_mon.status !== exp_r.status ||
						res_mon.last_result !== exp_r.last_result) begin
						$display("%0t mismatch: expected kind %0d pos %0h count %0d status %0d last %0d",
							$time, exp_r.kind, exp_r.position, exp_r.match_count,
							exp_r.status, exp_r.last_result);
						$display("%0t            actual kind %0d pos %0h count %0d status %0d last %0d",
							$time, res_mon.kind, res_mon.position, res_mon.match_count,
							res_mon.status, res_mon.last_result);
						fail_count++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				scan_byte(in_mon.data_byte, in_mon.last_byte);
			end
			pending = due_q.size();
		end
	end

endmodule

// ----- verif/tb_masked_signature_scanner.sv -----
// testbench top for the masked signature scanner: clock, reset, register writes,
// byte buffers with planted signatures and random handshake gaps; gives the verdict
// depends on mss_pkg, mss_if, masked_signature_scanner and mss_scan_checker
module tb_masked_signature_scanner;
	import mss_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 80;
	localparam int IDLE_PCT     = 14;
	localparam int PHASES       = 12;
	localparam int PHASE_BYTES  = 30;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_wdata = '0;

	mss_in_if  in_ch();
	mss_out_if res_ch();

	int fail_count;
	int pending;
	int cycles    = 0;
	bit idle_on   = 1'b1;
	bit hold_req  = 1'b0;
	int hold_left = 0;

	logic [127:0] sig_pat = '0;
	logic [127:0] sig_msk = '0;
	int           sig_len = 0;
	logic [7:0]   byte_q[$];

	masked_signature_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.src       (in_ch),
		.dst       (res_ch)
	);

	mss_scan_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_mon     (in_ch),
		.res_mon    (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_signature(input logic [63:0] lo, input logic [63:0] hi,
		input logic [63:0] mlo, input logic [63:0] mhi, input int len, input int tgt,
		input int lim);
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_MASK_LOW, mlo);
		write_reg(REG_MASK_HIGH, mhi);
		write_reg(REG_PATTERN_LENGTH, REG_W'(len));
		write_reg(REG_TARGET_OFFSET, REG_W'(tgt));
		write_reg(REG_MATCH_LIMIT, REG_W'(lim));
		sig_pat = {hi, lo};
		sig_msk = {mhi, mlo};
		sig_len = len;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		if (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_buffer();
		foreach (byte_q[i]) begin
			push_byte(byte_q[i], i == byte_q.size() - 1);
		end
		byte_q.delete();
	endtask

	// random buffer with copies of the signature planted at stride-aligned
	// offsets, or at misaligned ones when aligned is clear
	task automatic make_buffer(input int n, input int plant_pct, input bit aligned);
		logic [7:0] m;
		int         s;
		byte_q.delete();
		repeat (n) byte_q = {byte_q, 8'($urandom)};
		if (sig_len >= 1 && sig_len <= MAX_PATTERN_BYTES) begin
			s = aligned ? 0 : $urandom_range(1, SCAN_STRIDE - 1);
			while (s + sig_len <= n) begin
				if ($urandom_range(99) < plant_pct) begin
					for (int i = 0; i < sig_len; i++) begin
						m = sig_msk[i*8 +: 8];
						byte_q[s+i] = (sig_pat[i*8 +: 8] & m) | (8'($urandom) & ~m);
					end
				end
				s += SCAN_STRIDE;
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [127:0] msk;
		int           len;
		int           tgt;
		int           lim;
		int           sent;
		int           n;
		int           plant;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset registers: zero length, so the summary reports a bad signature
		byte_q = '{8'h00, 8'hFF};
		send_buffer();
		wait_idle();

		// four fixed bytes, limit two: matches, limit reached, match on final item,
		// buffer shorter than the signature
		set_signature(64'h0000_0000_EFBE_ADDE, '0, '1, '0, 4, 3, 2);
		byte_q = '{8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
			8'hDE, 8'hAD, 8'hBE, 8'hEF};
		send_buffer();
		byte_q = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
		send_buffer();
		byte_q = '{8'hDE, 8'hAD};
		send_buffer();
		wait_idle();

		// no fixed bits
		set_signature(64'h0000_0000_EFBE_ADDE, '0, '0, '0, 4, 3, 2);
		byte_q = '{8'h5A, 8'hA5};
		send_buffer();
		wait_idle();

		// target offset not below length
		set_signature(64'h0000_0000_EFBE_ADDE, '0, '1, '0, 4, 4, 2);
		byte_q = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
		send_buffer();
		wait_idle();

		for (int phase = 0; phase < PHASES; phase++) begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				case ($urandom_range(3))
					0: msk[i*8 +: 8] = 8'hFF;
					1: msk[i*8 +: 8] = $urandom_range(1) ? 8'hF0 : 8'h0F;
					2: msk[i*8 +: 8] = 8'($urandom);
					default: msk[i*8 +: 8] = 8'h00;
				endcase
			end
			len   = $urandom_range(1, MAX_PATTERN_BYTES);
			tgt   = $urandom_range(0, len - 1);
			lim   = $urandom_range(1, 4);
			plant = 40;
			case (phase)
				0: begin
					lo  = '0;
					hi  = '0;
					msk = '1;
					len = MAX_PATTERN_BYTES;
					tgt = 0;
					lim = 65535;
				end
				1: begin
					lo  = '1;
					hi  = '1;
					msk = '1;
					len = MAX_PATTERN_BYTES;
					tgt = 15;
					lim = 1;
				end
				2: begin
					len = 1;
					tgt = 0;
					lim = 0;
				end
				3: begin
					len = 20;
					tgt = 2;
				end
				4: begin
					msk   = '1;
					len   = 4;
					tgt   = 1;
					lim   = 65535;
					plant = 75;
				end
				default: begin
					case ($urandom_range(9))
						0: msk = '0;
						1: tgt = $urandom_range(len, 15);
						2: len = 0;
						default: begin
						end
					endcase
				end
			endcase
			set_signature(lo, hi, msk[63:0], msk[127:64], len, tgt, lim);
			if (phase == 4) begin
				hold_req = 1'b1;
			end
			if (phase == 6) begin
				idle_on = 1'b0;
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				n = $urandom_range(1, 40);
				make_buffer(n, plant, $urandom_range(99) < 80);
				send_buffer();
				sent += n;
			end
			wait_idle();
			idle_on = 1'b1;
		end

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
